### src/mtrs_pkg.sv
package mtrs_pkg;

	localparam logic [1:0] FUNC_STAGE  = 2'd0;
	localparam logic [1:0] FUNC_LAUNCH = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;
	localparam logic [1:0] FUNC_STOP   = 2'd3;

	localparam logic [1:0] ACT_OPEN  = 2'd0;
	localparam logic [1:0] ACT_CLOSE = 2'd1;
	localparam logic [1:0] ACT_SLEEP = 2'd2;

	localparam int REPORT_OUTPUTS = 16;

	typedef struct packed {
		logic [31:0] dur;
		logic [15:0] mask;
		logic [1:0]  act;
	} cmd_word_t;

	typedef struct packed {
		logic load_in;
		logic stage;
		logic launch_drop;
		logic launch_start;
		logic copy_rd;
		logic copy_wr;
		logic launch_fin;
		logic tick_start;
		logic tsel;
		logic texe;
		logic stop;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       stg_empty;
		logic       run_full;
		logic       copy_last;
		logic       k_done;
		logic       skip;
	} dp_sts_t;

endpackage

### src/mtrs_ctrl.sv
module mtrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output mtrs_pkg::dp_cmd_t cmd,
	input  mtrs_pkg::dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CP_RD,
		ST_CP_WR,
		ST_L_FIN,
		ST_T_SEL,
		ST_T_EXE,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign req_stall = (state_q != ST_IDLE) || (out_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_in = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.func)
					mtrs_pkg::FUNC_STAGE: begin
						cmd.stage = 1'b1;
						state_d   = ST_DONE;
					end
					mtrs_pkg::FUNC_LAUNCH: begin
						priority if (sts.stg_empty) begin
							state_d = ST_DONE;
						end else if (sts.run_full) begin
							cmd.launch_drop = 1'b1;
							state_d         = ST_DONE;
						end else begin
							cmd.launch_start = 1'b1;
							state_d          = ST_CP_RD;
						end
					end
					mtrs_pkg::FUNC_TICK: begin
						cmd.tick_start = 1'b1;
						state_d        = ST_T_SEL;
					end
					mtrs_pkg::FUNC_STOP: begin
						cmd.stop = 1'b1;
						state_d  = ST_DONE;
					end
				endcase
			end
			ST_CP_RD: begin
				cmd.copy_rd = 1'b1;
				state_d     = ST_CP_WR;
			end
			ST_CP_WR: begin
				cmd.copy_wr = 1'b1;
				state_d     = sts.copy_last ? ST_L_FIN : ST_CP_RD;
			end
			ST_L_FIN: begin
				cmd.launch_fin = 1'b1;
				state_d        = ST_DONE;
			end
			ST_T_SEL: begin
				priority if (sts.k_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.tsel = 1'b1;
					state_d  = sts.skip ? ST_T_SEL : ST_T_EXE;
				end
			end
			ST_T_EXE: begin
				cmd.texe = 1'b1;
				state_d  = ST_T_SEL;
			end
			ST_DONE: begin
				cmd.out_load = 1'b1;
				state_d      = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_done_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !out_valid_q)
		else $error("result loaded while previous item still held");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result valid without completion");

	a_exe_after_sel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_T_EXE |-> $past(state_q == ST_T_SEL))
		else $error("task execute without select");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");
`endif

endmodule

### src/mtrs_dpath.sv
module mtrs_dpath #(
	parameter int MAX_TASKS   = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int NUM_OUTPUTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mtrs_pkg::dp_cmd_t cmd,
	output mtrs_pkg::dp_sts_t sts,
	input  logic [1:0]        func,
	input  logic [1:0]        cmd_action,
	input  logic [15:0]       pin_mask,
	input  logic [31:0]       sleep_ms,
	input  logic [31:0]       now_ms,
	output logic [15:0]       relay_outputs,
	output logic [3:0]        active_tasks,
	output logic [4:0]        staged_commands,
	output logic              dropped
);

	localparam int SW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int RW    = $clog2(MAX_TASKS + 1);
	localparam int DEPTH = MAX_TASKS * QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int REPORT_BITS = mtrs_pkg::REPORT_OUTPUTS;

	logic [1:0]  func_q;
	logic [1:0]  act_q;
	logic [15:0] mask_q;
	logic [31:0] dur_q;
	logic [31:0] now_q;

	mtrs_pkg::cmd_word_t stg_mem [QUEUE_DEPTH];
	mtrs_pkg::cmd_word_t cmd_mem [DEPTH];
	mtrs_pkg::cmd_word_t stg_rd_s1;
	mtrs_pkg::cmd_word_t mem_rd_s1;

	logic [CW-1:0]          stg_fill_q;
	logic [RW-1:0]          rc_q;
	logic [NUM_OUTPUTS-1:0] levels_q;
	logic                   dropped_q;
	logic [RW-1:0]          k_q;
	logic [CW-1:0]          i_q;
	logic [SW-1:0]          slot_q;
	logic [SW-1:0]          slot_s1;
	logic                   pend_s1;
	logic [SW-1:0]          order_q [MAX_TASKS];
	logic [CW-1:0]          rpos_q  [MAX_TASKS];
	logic [CW-1:0]          fill_q  [MAX_TASKS];
	logic                   sleep_q [MAX_TASKS];
	logic [31:0]            wake_q  [MAX_TASKS];

	logic [15:0] relay_q;
	logic [3:0]  active_q;
	logic [4:0]  staged_q;
	logic        drop_out_q;

	logic [SW-1:0]          cur_slot;
	logic                   cur_sleep;
	logic                   cur_skip;
	logic                   cur_pend;
	logic [PW-1:0]          cur_pos;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic [SW-1:0]          launch_slot;
	logic                   act_ok;
	logic                   stg_full;
	logic [CW-1:0]          ex_pos_nxt;
	logic                   ex_sleep;
	logic                   ex_remove;
	logic [31:0]            ex_mask32;
	logic [NUM_OUTPUTS-1:0] ex_mask;
	logic [31:0]            lv32;

	assign cur_slot    = order_q[k_q[SW-1:0]];
	assign cur_sleep   = sleep_q[cur_slot];
	assign cur_skip    = cur_sleep && (now_q < wake_q[cur_slot]);
	assign cur_pend    = rpos_q[cur_slot] < fill_q[cur_slot];
	assign cur_pos     = rpos_q[cur_slot][PW-1:0];
	assign rd_addr     = AW'(32'(cur_slot) * 32'(QUEUE_DEPTH) + 32'(cur_pos));
	assign wr_addr     = AW'(32'(slot_q) * 32'(QUEUE_DEPTH) + 32'(i_q));
	assign launch_slot = order_q[rc_q[SW-1:0]];
	assign act_ok      = act_q <= mtrs_pkg::ACT_SLEEP;
	assign stg_full    = stg_fill_q >= CW'(QUEUE_DEPTH);

	assign ex_pos_nxt = rpos_q[slot_s1] + CW'(pend_s1);
	assign ex_sleep   = pend_s1 && (mem_rd_s1.act == mtrs_pkg::ACT_SLEEP);
	assign ex_remove  = (ex_pos_nxt >= fill_q[slot_s1]) && !ex_sleep;
	assign ex_mask32  = 32'(mem_rd_s1.mask);
	assign ex_mask    = ex_mask32[NUM_OUTPUTS-1:0];
	assign lv32       = 32'(levels_q);

	assign sts.func      = func_q;
	assign sts.stg_empty = stg_fill_q == '0;
	assign sts.run_full  = rc_q >= RW'(MAX_TASKS);
	assign sts.copy_last = (i_q + CW'(1)) >= stg_fill_q;
	assign sts.k_done    = k_q >= rc_q;
	assign sts.skip      = cur_skip;

	assign relay_outputs   = relay_q;
	assign active_tasks    = active_q;
	assign staged_commands = staged_q;
	assign dropped         = drop_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			act_q  <= cmd_action;
			mask_q <= pin_mask;
			dur_q  <= sleep_ms;
			now_q  <= now_ms;
		end
		if (cmd.out_load) begin
			relay_q    <= lv32[REPORT_BITS-1:0];
			active_q   <= 4'(rc_q);
			staged_q   <= 5'(stg_fill_q);
			drop_out_q <= dropped_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.stage && act_ok && !stg_full) begin
			stg_mem[stg_fill_q[PW-1:0]] <= mtrs_pkg::cmd_word_t'{dur: dur_q, mask: mask_q,
				act: act_q};
		end
		if (cmd.copy_rd) begin
			stg_rd_s1 <= stg_mem[i_q[PW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_wr) begin
			cmd_mem[wr_addr] <= stg_rd_s1;
		end
		if (cmd.tsel) begin
			mem_rd_s1 <= cmd_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_fill_q <= '0;
			rc_q       <= '0;
			levels_q   <= '0;
			dropped_q  <= 1'b0;
			k_q        <= '0;
			i_q        <= '0;
			slot_q     <= '0;
			slot_s1    <= '0;
			pend_s1    <= 1'b0;
			for (int j = 0; j < MAX_TASKS; j++) begin
				order_q[j] <= SW'(j);
				rpos_q[j]  <= '0;
				fill_q[j]  <= '0;
				sleep_q[j] <= 1'b0;
				wake_q[j]  <= '0;
			end
		end else begin
			if (cmd.load_in) begin
				dropped_q <= 1'b0;
			end
			if (cmd.stage && act_ok) begin
				if (stg_full) begin
					dropped_q <= 1'b1;
				end else begin
					stg_fill_q <= stg_fill_q + CW'(1);
				end
			end
			if (cmd.launch_drop) begin
				dropped_q  <= 1'b1;
				stg_fill_q <= '0;
			end
			if (cmd.launch_start) begin
				slot_q <= launch_slot;
				i_q    <= '0;
			end
			if (cmd.copy_wr) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.launch_fin) begin
				rpos_q[slot_q]  <= '0;
				fill_q[slot_q]  <= stg_fill_q;
				sleep_q[slot_q] <= 1'b0;
				wake_q[slot_q]  <= '0;
				rc_q            <= rc_q + RW'(1);
				stg_fill_q      <= '0;
			end
			if (cmd.tick_start) begin
				k_q <= '0;
			end
			if (cmd.tsel) begin
				if (cur_skip) begin
					k_q <= k_q + RW'(1);
				end else begin
					if (cur_sleep) begin
						sleep_q[cur_slot] <= 1'b0;
					end
					slot_s1 <= cur_slot;
					pend_s1 <= cur_pend;
				end
			end
			if (cmd.texe) begin
				if (pend_s1) begin
					rpos_q[slot_s1] <= ex_pos_nxt;
					priority if (mem_rd_s1.act == mtrs_pkg::ACT_SLEEP) begin
						sleep_q[slot_s1] <= 1'b1;
						wake_q[slot_s1]  <= now_q + mem_rd_s1.dur;
					end else if (mem_rd_s1.act == mtrs_pkg::ACT_CLOSE) begin
						levels_q <= levels_q | ex_mask;
					end else begin
						levels_q <= levels_q & ~ex_mask;
					end
				end
				if (ex_remove) begin
					for (int j = 0; j < MAX_TASKS - 1; j++) begin
						if (RW'(j) >= k_q && RW'(j + 1) < rc_q) begin
							order_q[j] <= order_q[j + 1];
						end
					end
					for (int j = 0; j < MAX_TASKS; j++) begin
						if (RW'(j) == rc_q - RW'(1)) begin
							order_q[j] <= slot_s1;
						end
					end
					rc_q <= rc_q - RW'(1);
				end else begin
					k_q <= k_q + RW'(1);
				end
			end
			if (cmd.stop) begin
				rc_q <= '0;
				for (int j = 0; j < MAX_TASKS; j++) begin
					order_q[j] <= SW'(j);
				end
			end
		end
	end

endmodule

### src/multi_task_relay_sequencer.sv
// Relay sequencer running up to MAX_TASKS command scripts in launch order. An item is
// accepted only while the block is idle and no held result is stalled; its result follows
// in a held output register. Stage, stop, empty launch and rejected launch items go from
// execute straight to the result load; a launch first copies each staged command, read
// from the staging buffer and then written into the single-port command store. A tick
// walks tasks one at a time: a sleeping task that stays asleep is only selected, a task
// that runs gets one registered store read and then executes. The command store
// (MAX_TASKS x QUEUE_DEPTH entries) is not cleared after reset; only launched entries are used.
module multi_task_relay_sequencer #(
	parameter int MAX_TASKS   = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int NUM_OUTPUTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  func,
	input  logic [1:0]  cmd_action,
	input  logic [15:0] pin_mask,
	input  logic [31:0] sleep_ms,
	input  logic [31:0] now_ms,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] relay_outputs,
	output logic [3:0]  active_tasks,
	output logic [4:0]  staged_commands,
	output logic        dropped
);

	mtrs_pkg::dp_cmd_t cmd;
	mtrs_pkg::dp_sts_t sts;

	mtrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	mtrs_dpath #(
		.MAX_TASKS   (MAX_TASKS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_OUTPUTS (NUM_OUTPUTS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (func),
		.cmd_action      (cmd_action),
		.pin_mask        (pin_mask),
		.sleep_ms        (sleep_ms),
		.now_ms          (now_ms),
		.relay_outputs   (relay_outputs),
		.active_tasks    (active_tasks),
		.staged_commands (staged_commands),
		.dropped         (dropped)
	);

endmodule
